// ===== hw/rtl/wu_line_pkg.sv =====
// Shared types and constants for the Wu antialiased line stepper.
package wu_line_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_HORIZ,
        MODE_VERT,
        MODE_DIAG,
        MODE_YMAJ,
        MODE_XMAJ
    } line_mode_t;

    localparam int IN_COORD_BITS  = 12;
    localparam int OUT_COORD_BITS = 14;
    localparam int WEIGHT_BITS    = 8;
    localparam int FRAME_BITS     = 13;
    localparam int FRAC_BITS      = 16;
    localparam int DIV_CNT_BITS   = $clog2(FRAC_BITS);

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_FULL       = 8'hFF;
    localparam logic [FRAME_BITS-1:0]  FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [FRAME_BITS-1:0]  FRAME_HEIGHT_RESET = 13'd480;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic ACTION_START = 1'b0;

endpackage

// ===== hw/rtl/wu_antialiased_line_stepper.sv =====
// Wu antialiased line stepper: start/step stream in, at most one pixel per transaction out.
//
// A start transaction (tuser = 0) loads two endpoints, orders them top to bottom and
// delivers the first pixel in the next cycle. For a line that is neither horizontal,
// vertical nor diagonal, a restoring divider then forms the 16-bit error step one
// quotient bit per cycle, and s_axis_tready stays low until it is done. A step
// transaction (tuser = 1) advances the line by one pixel and delivers that pixel in
// the next cycle; steps sustain one transaction per cycle while results are taken.
// A step with no line in progress yields no result. Results sit in an output
// register, and a new input transaction is taken when no result is held or the held
// result is taken in the same cycle. The inside-frame flags compare each pixel
// against frame_width (register 0) and frame_height (register 1), written through
// the cfg channel at any time the block is idle.
module wu_antialiased_line_stepper #(
    parameter int COORD_BITS = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_x [11:0], start_y [23:12], end_x [35:24], end_y [47:36]
    input  logic [47:0]  s_axis_tdata,
    // action [0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // main_x [13:0], main_y [27:14], main_weight [35:28], pair_valid [36],
    // pair_x [50:37], pair_y [64:51], pair_weight [72:65], main_inside [73],
    // pair_inside [74], zero fill [79:75]
    output logic [79:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [12:0]  cfg_data
);

    localparam int CB  = COORD_BITS;
    localparam int CW  = CB + 2;
    localparam int CMP = (CW - 1 > wu_line_pkg::FRAME_BITS) ? CW - 1 : wu_line_pkg::FRAME_BITS;
    localparam int FB  = wu_line_pkg::FRAC_BITS;
    localparam int WB  = wu_line_pkg::WEIGHT_BITS;
    localparam int OB  = wu_line_pkg::OUT_COORD_BITS;
    localparam int NB  = wu_line_pkg::DIV_CNT_BITS;
    localparam int IB  = wu_line_pkg::IN_COORD_BITS;

    typedef enum logic {
        ST_RUN,
        ST_DIV
    } state_t;

    function automatic logic inside_frame(
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] y,
        input logic [wu_line_pkg::FRAME_BITS-1:0] fw,
        input logic [wu_line_pkg::FRAME_BITS-1:0] fh
    );
        logic [CMP-1:0] ux;
        logic [CMP-1:0] uy;
        ux = CMP'(x[CW-2:0]);
        uy = CMP'(y[CW-2:0]);
        return !x[CW-1] && (ux < CMP'(fw)) && !y[CW-1] && (uy < CMP'(fh));
    endfunction

    state_t                 state_reg, state_next;
    wu_line_pkg::line_mode_t mode_reg, mode_next;
    logic                   xneg_reg, xneg_next;
    logic signed [CW-1:0]   cur_x_reg, cur_x_next;
    logic signed [CW-1:0]   cur_y_reg, cur_y_next;
    logic [CB-1:0]          final_x_reg, final_x_next;
    logic [CB-1:0]          final_y_reg, final_y_next;
    logic [FB-1:0]          acc_reg, acc_next;
    logic [FB-1:0]          step_reg, step_next;
    logic [CB-1:0]          steps_reg, steps_next;
    logic [CB-1:0]          div_rem_reg, div_rem_next;
    logic [CB-1:0]          div_den_reg, div_den_next;
    logic [NB-1:0]          div_cnt_reg, div_cnt_next;
    logic [wu_line_pkg::FRAME_BITS-1:0] frame_w_reg, frame_w_next;
    logic [wu_line_pkg::FRAME_BITS-1:0] frame_h_reg, frame_h_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OB-1:0]          out_main_x_reg, out_main_x_next;
    logic [OB-1:0]          out_main_y_reg, out_main_y_next;
    logic [WB-1:0]          out_main_w_reg, out_main_w_next;
    logic                   out_pv_reg, out_pv_next;
    logic [OB-1:0]          out_pair_x_reg, out_pair_x_next;
    logic [OB-1:0]          out_pair_y_reg, out_pair_y_next;
    logic [WB-1:0]          out_pair_w_reg, out_pair_w_next;
    logic                   out_main_in_reg, out_main_in_next;
    logic                   out_pair_in_reg, out_pair_in_next;
    logic                   out_last_reg, out_last_next;

    // input decode
    logic                   in_fire;
    logic [CB-1:0]          in_x0, in_y0, in_x1, in_y1;
    logic [CB-1:0]          sx0, sy0, sx1, sy1;
    logic                   swap;
    logic signed [CB:0]     dx_s;
    logic [CB-1:0]          adx, dy;

    // stepping
    logic signed [CW-1:0]   x_adv, y_adv;
    logic [FB-1:0]          acc_sum;
    logic                   wrap;

    // divider
    logic [CB:0]            div_trial;
    logic                   div_ge;

    // pixel to emit
    logic                   em_valid;
    logic signed [CW-1:0]   em_mx, em_my, em_px, em_py;
    logic [WB-1:0]          em_w;
    logic                   em_pv;
    logic                   em_last;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_RUN) && (!out_valid_reg || m_axis_tready);
    assign cfg_ready     = 1'b1;

    assign in_x0 = CB'(s_axis_tdata[IB-1:0]);
    assign in_y0 = CB'(s_axis_tdata[2*IB-1:IB]);
    assign in_x1 = CB'(s_axis_tdata[3*IB-1:2*IB]);
    assign in_y1 = CB'(s_axis_tdata[4*IB-1:3*IB]);

    assign swap = in_y0 > in_y1;
    assign sx0  = swap ? in_x1 : in_x0;
    assign sy0  = swap ? in_y1 : in_y0;
    assign sx1  = swap ? in_x0 : in_x1;
    assign sy1  = swap ? in_y0 : in_y1;
    assign dx_s = $signed({1'b0, sx1}) - $signed({1'b0, sx0});
    assign adx  = dx_s[CB] ? CB'(-dx_s) : dx_s[CB-1:0];
    assign dy   = sy1 - sy0;

    assign x_adv   = xneg_reg ? cur_x_reg - CW'(1) : cur_x_reg + CW'(1);
    assign y_adv   = cur_y_reg + CW'(1);
    assign acc_sum = acc_reg + step_reg;
    assign wrap    = acc_sum <= acc_reg;

    // one quotient bit per cycle
    assign div_trial = {div_rem_reg, 1'b0};
    assign div_ge    = div_trial >= {1'b0, div_den_reg};

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        xneg_next    = xneg_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        final_x_next = final_x_reg;
        final_y_next = final_y_reg;
        acc_next     = acc_reg;
        step_next    = step_reg;
        steps_next   = steps_reg;
        div_rem_next = div_rem_reg;
        div_den_next = div_den_reg;
        div_cnt_next = div_cnt_reg;
        frame_w_next = frame_w_reg;
        frame_h_next = frame_h_reg;

        em_valid = 1'b0;
        em_mx    = cur_x_reg;
        em_my    = cur_y_reg;
        em_w     = wu_line_pkg::WEIGHT_FULL;
        em_pv    = 1'b0;
        em_px    = '0;
        em_py    = '0;
        em_last  = 1'b0;

        if (cfg_valid)
        begin
            if (cfg_index == wu_line_pkg::CFG_FRAME_WIDTH)
                frame_w_next = cfg_data;
            else
                frame_h_next = cfg_data;
        end

        if (state_reg == ST_DIV)
        begin
            step_next    = {step_reg[FB-2:0], div_ge};
            div_rem_next = div_ge ? CB'(div_trial - {1'b0, div_den_reg}) : CB'(div_trial);
            div_cnt_next = div_cnt_reg + NB'(1);
            if (div_cnt_reg == NB'(FB - 1))
                state_next = ST_RUN;
        end
        else if (in_fire && s_axis_tuser == wu_line_pkg::ACTION_START)
        begin
            cur_x_next   = $signed({2'b00, sx0});
            cur_y_next   = $signed({2'b00, sy0});
            final_x_next = sx1;
            final_y_next = sy1;
            xneg_next    = dx_s[CB];
            acc_next     = '0;
            step_next    = '0;
            div_cnt_next = '0;
            if (dy == '0)
            begin
                mode_next  = (adx == '0) ? wu_line_pkg::MODE_IDLE : wu_line_pkg::MODE_HORIZ;
                steps_next = adx;
            end
            else if (adx == '0)
            begin
                mode_next  = wu_line_pkg::MODE_VERT;
                steps_next = dy;
            end
            else if (adx == dy)
            begin
                mode_next  = wu_line_pkg::MODE_DIAG;
                steps_next = dy;
            end
            else if (dy > adx)
            begin
                mode_next    = wu_line_pkg::MODE_YMAJ;
                steps_next   = dy;
                div_rem_next = adx;
                div_den_next = dy;
                state_next   = ST_DIV;
            end
            else
            begin
                mode_next    = wu_line_pkg::MODE_XMAJ;
                steps_next   = adx;
                div_rem_next = dy;
                div_den_next = adx;
                state_next   = ST_DIV;
            end
            em_valid = 1'b1;
            em_mx    = $signed({2'b00, sx0});
            em_my    = $signed({2'b00, sy0});
            em_last  = (dy == '0) && (adx == '0);
        end
        else if (in_fire)
        begin
            if (mode_reg == wu_line_pkg::MODE_IDLE || steps_reg == '0)
            begin
                // nothing left to draw: drop the step
                mode_next = wu_line_pkg::MODE_IDLE;
            end
            else if (mode_reg == wu_line_pkg::MODE_YMAJ || mode_reg == wu_line_pkg::MODE_XMAJ)
            begin
                em_valid = 1'b1;
                if (steps_reg == CB'(1))
                begin
                    steps_next = '0;
                    mode_next  = wu_line_pkg::MODE_IDLE;
                    cur_x_next = $signed({2'b00, final_x_reg});
                    cur_y_next = $signed({2'b00, final_y_reg});
                    em_mx      = $signed({2'b00, final_x_reg});
                    em_my      = $signed({2'b00, final_y_reg});
                    em_last    = 1'b1;
                end
                else
                begin
                    acc_next   = acc_sum;
                    steps_next = steps_reg - CB'(1);
                    em_w       = acc_sum[FB-1:FB-WB];
                    em_pv      = 1'b1;
                    if (mode_reg == wu_line_pkg::MODE_YMAJ)
                    begin
                        cur_x_next = wrap ? x_adv : cur_x_reg;
                        cur_y_next = y_adv;
                        em_px      = xneg_next ? cur_x_next - CW'(1) : cur_x_next + CW'(1);
                        em_py      = cur_y_next;
                    end
                    else
                    begin
                        cur_x_next = x_adv;
                        cur_y_next = wrap ? y_adv : cur_y_reg;
                        em_px      = cur_x_next;
                        em_py      = cur_y_next + CW'(1);
                    end
                    em_mx = cur_x_next;
                    em_my = cur_y_next;
                end
            end
            else
            begin
                em_valid = 1'b1;
                if (mode_reg != wu_line_pkg::MODE_VERT)
                    cur_x_next = x_adv;
                if (mode_reg != wu_line_pkg::MODE_HORIZ)
                    cur_y_next = y_adv;
                steps_next = steps_reg - CB'(1);
                em_last    = steps_reg == CB'(1);
                if (em_last)
                    mode_next = wu_line_pkg::MODE_IDLE;
                em_mx = cur_x_next;
                em_my = cur_y_next;
            end
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_main_x_next  = out_main_x_reg;
        out_main_y_next  = out_main_y_reg;
        out_main_w_next  = out_main_w_reg;
        out_pv_next      = out_pv_reg;
        out_pair_x_next  = out_pair_x_reg;
        out_pair_y_next  = out_pair_y_reg;
        out_pair_w_next  = out_pair_w_reg;
        out_main_in_next = out_main_in_reg;
        out_pair_in_next = out_pair_in_reg;
        out_last_next    = out_last_reg;
        if (em_valid)
        begin
            out_valid_next   = 1'b1;
            out_main_x_next  = OB'(em_mx);
            out_main_y_next  = OB'(em_my);
            out_main_w_next  = em_w;
            out_pv_next      = em_pv;
            out_pair_x_next  = em_pv ? OB'(em_px) : '0;
            out_pair_y_next  = em_pv ? OB'(em_py) : '0;
            out_pair_w_next  = em_pv ? (em_w ^ wu_line_pkg::WEIGHT_FULL) : '0;
            out_main_in_next = inside_frame(em_mx, em_my, frame_w_reg, frame_h_reg);
            out_pair_in_next = em_pv && inside_frame(em_px, em_py, frame_w_reg, frame_h_reg);
            out_last_next    = em_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            mode_reg        <= wu_line_pkg::MODE_IDLE;
            xneg_reg        <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            final_x_reg     <= '0;
            final_y_reg     <= '0;
            acc_reg         <= '0;
            step_reg        <= '0;
            steps_reg       <= '0;
            div_rem_reg     <= '0;
            div_den_reg     <= '0;
            div_cnt_reg     <= '0;
            frame_w_reg     <= wu_line_pkg::FRAME_WIDTH_RESET;
            frame_h_reg     <= wu_line_pkg::FRAME_HEIGHT_RESET;
            out_valid_reg   <= 1'b0;
            out_main_x_reg  <= '0;
            out_main_y_reg  <= '0;
            out_main_w_reg  <= '0;
            out_pv_reg      <= 1'b0;
            out_pair_x_reg  <= '0;
            out_pair_y_reg  <= '0;
            out_pair_w_reg  <= '0;
            out_main_in_reg <= 1'b0;
            out_pair_in_reg <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            xneg_reg        <= xneg_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            final_x_reg     <= final_x_next;
            final_y_reg     <= final_y_next;
            acc_reg         <= acc_next;
            step_reg        <= step_next;
            steps_reg       <= steps_next;
            div_rem_reg     <= div_rem_next;
            div_den_reg     <= div_den_next;
            div_cnt_reg     <= div_cnt_next;
            frame_w_reg     <= frame_w_next;
            frame_h_reg     <= frame_h_next;
            out_valid_reg   <= out_valid_next;
            out_main_x_reg  <= out_main_x_next;
            out_main_y_reg  <= out_main_y_next;
            out_main_w_reg  <= out_main_w_next;
            out_pv_reg      <= out_pv_next;
            out_pair_x_reg  <= out_pair_x_next;
            out_pair_y_reg  <= out_pair_y_next;
            out_pair_w_reg  <= out_pair_w_next;
            out_main_in_reg <= out_main_in_next;
            out_pair_in_reg <= out_pair_in_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'b00000, out_pair_in_reg, out_main_in_reg, out_pair_w_reg,
                            out_pair_y_reg, out_pair_x_reg, out_pv_reg, out_main_w_reg,
                            out_main_y_reg, out_main_x_reg};

endmodule

// ===== dv/wu_antialiased_line_stepper_checker.sv =====
// Pixel predictor and scoreboard for the Wu line stepper streams.
`timescale 1ns / 100ps

module wu_antialiased_line_stepper_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [13:0] main_x;
        logic [13:0] main_y;
        logic [7:0]  main_weight;
        logic        pair_valid;
        logic [13:0] pair_x;
        logic [13:0] pair_y;
        logic [7:0]  pair_weight;
        logic        main_inside;
        logic        pair_inside;
        logic        last;
    } pixel_t;

    pixel_t expected_pixels[$];
    int     mismatches;

    logic [wu_line_pkg::FRAME_BITS-1:0]  frame_w;
    logic [wu_line_pkg::FRAME_BITS-1:0]  frame_h;
    logic signed [13:0]                  pos_x;
    logic signed [13:0]                  pos_y;
    logic [11:0]                         stop_x;
    logic [11:0]                         stop_y;
    logic [wu_line_pkg::FRAC_BITS-1:0]   err_acc;
    logic [wu_line_pkg::FRAC_BITS-1:0]   err_step;
    logic [12:0]                         steps_left;
    wu_line_pkg::line_mode_t             mode;
    logic                                x_neg;

    assign fail_count = mismatches;

    function automatic logic on_frame(logic signed [13:0] x, logic signed [13:0] y);
        return (x >= 0) && (x < $signed({1'b0, frame_w})) &&
               (y >= 0) && (y < $signed({1'b0, frame_h}));
    endfunction

    function automatic void queue_pixel(logic signed [13:0] mx, logic signed [13:0] my,
                                        logic [7:0] w, logic pv,
                                        logic signed [13:0] px, logic signed [13:0] py,
                                        logic lst);
        pixel_t p;
        p.main_x      = mx;
        p.main_y      = my;
        p.main_weight = w;
        p.pair_valid  = pv;
        // zero all pair fields when there is no neighbor pixel
        p.pair_x      = pv ? px : '0;
        p.pair_y      = pv ? py : '0;
        p.pair_weight = pv ? ~w : '0;
        p.main_inside = on_frame(mx, my);
        p.pair_inside = pv && on_frame(px, py);
        p.last        = lst;
        expected_pixels.push_back(p);
    endfunction

    task automatic step_line(input logic act, input logic [47:0] data);
        logic [11:0]        x0, y0, x1, y1, tmp, dx_mag, dy;
        logic signed [12:0] dx;
        logic signed [13:0] dir;
        logic [15:0]        prev_acc;
        if (act == wu_line_pkg::ACTION_START) begin
            x0 = data[11:0];
            y0 = data[23:12];
            x1 = data[35:24];
            y1 = data[47:36];
            // order the endpoints top to bottom
            if (y0 > y1) begin
                tmp = y0; y0 = y1; y1 = tmp;
                tmp = x0; x0 = x1; x1 = tmp;
            end
            pos_x  = $signed({2'b00, x0});
            pos_y  = $signed({2'b00, y0});
            stop_x = x1;
            stop_y = y1;
            dx     = $signed({1'b0, x1}) - $signed({1'b0, x0});
            x_neg  = dx < 0;
            dx_mag = x_neg ? 12'(-dx) : 12'(dx);
            dy     = y1 - y0;
            err_acc  = '0;
            err_step = '0;
            if (dy == 0) begin
                if (dx_mag == 0)
                    mode = wu_line_pkg::MODE_IDLE;
                else
                    mode = wu_line_pkg::MODE_HORIZ;
                steps_left = {1'b0, dx_mag};
            end else if (dx_mag == 0) begin
                mode       = wu_line_pkg::MODE_VERT;
                steps_left = {1'b0, dy};
            end else if (dx_mag == dy) begin
                mode       = wu_line_pkg::MODE_DIAG;
                steps_left = {1'b0, dy};
            end else if (dy > dx_mag) begin
                mode       = wu_line_pkg::MODE_YMAJ;
                steps_left = {1'b0, dy};
                err_step   = 16'({dx_mag, 16'h0000} / dy);
            end else begin
                mode       = wu_line_pkg::MODE_XMAJ;
                steps_left = {1'b0, dx_mag};
                err_step   = 16'({dy, 16'h0000} / dx_mag);
            end
            queue_pixel(pos_x, pos_y, wu_line_pkg::WEIGHT_FULL, 1'b0, '0, '0,
                        mode == wu_line_pkg::MODE_IDLE);
        end else if (mode == wu_line_pkg::MODE_IDLE || steps_left == 0) begin
            mode = wu_line_pkg::MODE_IDLE;
        end else begin
            dir = x_neg ? -14'sd1 : 14'sd1;
            if (mode == wu_line_pkg::MODE_YMAJ || mode == wu_line_pkg::MODE_XMAJ) begin
                if (steps_left == 1) begin
                    steps_left = '0;
                    mode       = wu_line_pkg::MODE_IDLE;
                    pos_x      = $signed({2'b00, stop_x});
                    pos_y      = $signed({2'b00, stop_y});
                    queue_pixel(pos_x, pos_y, wu_line_pkg::WEIGHT_FULL, 1'b0, '0, '0, 1'b1);
                end else begin
                    prev_acc   = err_acc;
                    err_acc    = err_acc + err_step;
                    steps_left = steps_left - 1'b1;
                    // a wrap of the accumulator moves the minor axis
                    if (mode == wu_line_pkg::MODE_YMAJ) begin
                        if (err_acc <= prev_acc)
                            pos_x = pos_x + dir;
                        pos_y = pos_y + 14'sd1;
                        queue_pixel(pos_x, pos_y, err_acc[15:8], 1'b1,
                                    pos_x + dir, pos_y, 1'b0);
                    end else begin
                        if (err_acc <= prev_acc)
                            pos_y = pos_y + 14'sd1;
                        pos_x = pos_x + dir;
                        queue_pixel(pos_x, pos_y, err_acc[15:8], 1'b1,
                                    pos_x, pos_y + 14'sd1, 1'b0);
                    end
                end
            end else begin
                if (mode != wu_line_pkg::MODE_VERT)
                    pos_x = pos_x + dir;
                if (mode != wu_line_pkg::MODE_HORIZ)
                    pos_y = pos_y + 14'sd1;
                steps_left = steps_left - 1'b1;
                if (steps_left == 0)
                    mode = wu_line_pkg::MODE_IDLE;
                queue_pixel(pos_x, pos_y, wu_line_pkg::WEIGHT_FULL, 1'b0, '0, '0,
                            steps_left == 0);
            end
        end
    endtask

    function automatic void check_field(string name, logic [13:0] want, logic [13:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endfunction

    task automatic compare_pixel();
        pixel_t want;
        if (expected_pixels.size() == 0) begin
            mismatches++;
            $error("pixel transaction with nothing expected: tdata 0x%0h", m_axis_tdata);
        end else begin
            want = expected_pixels.pop_front();
            check_field("main_x",      want.main_x,      m_axis_tdata[13:0]);
            check_field("main_y",      want.main_y,      m_axis_tdata[27:14]);
            check_field("main_weight", want.main_weight, m_axis_tdata[35:28]);
            check_field("pair_valid",  want.pair_valid,  m_axis_tdata[36]);
            check_field("pair_x",      want.pair_x,      m_axis_tdata[50:37]);
            check_field("pair_y",      want.pair_y,      m_axis_tdata[64:51]);
            check_field("pair_weight", want.pair_weight, m_axis_tdata[72:65]);
            check_field("main_inside", want.main_inside, m_axis_tdata[73]);
            check_field("pair_inside", want.pair_inside, m_axis_tdata[74]);
            check_field("last",        want.last,        m_axis_tlast);
        end
    endtask

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            expected_pixels.delete();
            frame_w    = wu_line_pkg::FRAME_WIDTH_RESET;
            frame_h    = wu_line_pkg::FRAME_HEIGHT_RESET;
            pos_x      = '0;
            pos_y      = '0;
            stop_x     = '0;
            stop_y     = '0;
            err_acc    = '0;
            err_step   = '0;
            steps_left = '0;
            mode       = wu_line_pkg::MODE_IDLE;
            x_neg      = 1'b0;
            pending   <= 0;
        end else begin
            // retire the older result before queuing a new one
            if (m_axis_tvalid && m_axis_tready)
                compare_pixel();
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == wu_line_pkg::CFG_FRAME_WIDTH)
                    frame_w = cfg_data;
                else
                    frame_h = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                step_line(s_axis_tuser, s_axis_tdata);
            pending <= expected_pixels.size();
        end
    end

endmodule

// ===== dv/wu_antialiased_line_stepper_test.sv =====
// Stimulus and verdict for the Wu line stepper testbench.
`timescale 1ns / 100ps

module wu_antialiased_line_stepper_test;

    localparam logic ACTION_STEP   = ~wu_line_pkg::ACTION_START;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   TIMEOUT_NS    = 5_000_000;
    localparam int   PHASE_COUNT   = 6;
    localparam int   PHASE_ITEMS   = 225;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [12:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    wu_antialiased_line_stepper u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    wu_antialiased_line_stepper_checker u_checker (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_item(input logic act, input logic [47:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic draw(input logic [11:0] x0, y0, x1, y1, input int steps);
        send_item(wu_line_pkg::ACTION_START, {y1, x1, y0, x0});
        repeat (steps)
            send_item(ACTION_STEP, 48'({$urandom, $urandom}));
    endtask

    // hold off until every pixel is back and the divider has had time to finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_frame(input logic [12:0] w, input logic [12:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= wu_line_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= wu_line_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [11:0] near(logic [11:0] v, int span);
        int t;
        t = int'(v) + int'($urandom_range(2 * span)) - span;
        if (t < 0)
            t = 0;
        if (t > 4095)
            t = 4095;
        return 12'(t);
    endfunction

    task automatic run_lines(input int goal);
        int          counted, roll, len, n, k, d, dxm, dym;
        logic [11:0] x0, y0, x1, y1, tmp;
        logic        big;
        counted = 0;
        while (counted < goal) begin
            // stray step between lines
            if ($urandom_range(99) < 4)
                send_item(ACTION_STEP, 48'({$urandom, $urandom}));
            roll = $urandom_range(99);
            big  = 1'b0;
            x0   = 12'($urandom);
            y0   = 12'($urandom);
            if (roll < 6) begin
                big = 1'b1;
                x1  = 12'($urandom);
                y1  = 12'($urandom);
            end else if (roll < 14) begin
                x1 = near(x0, 24);
                y1 = y0;
            end else if (roll < 22) begin
                x1 = x0;
                y1 = near(y0, 24);
            end else if (roll < 32) begin
                d  = $urandom_range(1, 20);
                x0 = 12'($urandom_range(20, 4075));
                y0 = 12'($urandom_range(0, 4075));
                x1 = $urandom_range(1) ? x0 + 12'(d) : x0 - 12'(d);
                y1 = y0 + 12'(d);
                if ($urandom_range(1)) begin
                    tmp = x0; x0 = x1; x1 = tmp;
                    tmp = y0; y0 = y1; y1 = tmp;
                end
            end else if (roll < 36) begin
                x1 = x0;
                y1 = y0;
            end else begin
                x1 = near(x0, 24);
                y1 = near(y0, 24);
            end
            dxm = (x1 > x0) ? int'(x1 - x0) : int'(x0 - x1);
            dym = (y1 > y0) ? int'(y1 - y0) : int'(y0 - y1);
            len = (dxm > dym) ? dxm : dym;
            send_item(wu_line_pkg::ACTION_START, {y1, x1, y0, x0});
            counted++;
            roll = $urandom_range(99);
            // long lines are cut short by the next start unless the random step count reaches their length
            if (big)
                n = $urandom_range(3, 30);
            else if (roll < 8)
                n = $urandom_range(0, len);
            else if (roll < 16)
                n = len + $urandom_range(1, 2);
            else
                n = len;
            if (big && n > len)
                n = len;
            for (k = 0; k < n; k++) begin
                send_item(ACTION_STEP, 48'({$urandom, $urandom}));
                if (k < len)
                    counted++;
            end
        end
    endtask

    initial begin
        logic [12:0] widths[PHASE_COUNT];
        logic [12:0] heights[PHASE_COUNT];
        int          p;
        widths  = '{13'd4096, 13'd1, 13'd0, 13'd100, 13'd4096, 13'd2000};
        heights = '{13'd4096, 13'd1, 13'd4096, 13'd3000, 13'd0, 13'd4096};
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        // directed lines at the reset frame size
        send_idle_pct = 29;
        recv_idle_pct = 64;
        draw(12'd0, 12'd0, 12'd0, 12'd0, 1);
        draw(12'd4095, 12'd4095, 12'd4095, 12'd4095, 0);
        draw(12'd10, 12'd5, 12'd14, 12'd5, 5);
        draw(12'd639, 12'd481, 12'd639, 12'd478, 3);
        draw(12'd20, 12'd0, 12'd17, 12'd3, 3);
        draw(12'd100, 12'd100, 12'd102, 12'd104, 4);
        draw(12'd4095, 12'd0, 12'd0, 12'd4095, 1);
        draw(12'd50, 12'd10, 12'd46, 12'd11, 4);

        for (p = 0; p < PHASE_COUNT; p++) begin
            settle();
            set_frame(widths[p], heights[p]);
            case (p / 2)
                0: begin send_idle_pct = 29; recv_idle_pct = 64; end
                1: begin send_idle_pct = 64; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            run_lines(PHASE_ITEMS);
        end
        settle();

        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
